@@ hdl/twor_pkg.sv @@
// shared constants and types for the triangle winding orientation core
`timescale 1ns / 1ps
`default_nettype none

package twor_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int INDEX_BITS_DEF = 16;
    localparam int CFG_IDX_W      = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORTHO_MODE = 3'd0,
        CFG_VIEW_X     = 3'd1,
        CFG_VIEW_Y     = 3'd2,
        CFG_VIEW_Z     = 3'd3,
        CFG_EYE_X      = 3'd4,
        CFG_EYE_Y      = 3'd5,
        CFG_EYE_Z      = 3'd6
    } t_cfg_reg;

    // load enables for the three cross product stages
    typedef struct packed {
        logic ld_edge;
        logic ld_prod;
        logic ld_norm;
    } t_cross_ctl;

endpackage

`default_nettype wire

@@ hdl/triangle_winding_orient_core.sv @@
// Triangle winding orientation core: takes one triangle per cycle unless output back-pressure stalls it,
// forms its face normal and swaps the second and third vertex index when the normal points away from the
// viewer. The datapath is a six stage pipeline (edges, edge products, normal, split dot product partial
// products, partial sums, final sum and sign); each stage holds at most one multiply or one wide add.
// Stages stall independently, so empty slots fill even while the output word waits. The normal and the
// dot product are exact, only the sign of the dot product and the all-zero test of the normal decide the
// result. The user must write configuration only while idle; the core itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module triangle_winding_orient_core
    import twor_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    localparam int IN_W        = 9 * COORD_BITS + 2 * INDEX_BITS,
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((2 * INDEX_BITS + 7) / 8) * 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // config write port
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [COORD_BITS-1:0]  i_cfg_data,
    // input stream
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, second_index, third_index
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // output stream
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // second_index_out, third_index_out
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // swapped, degenerate
    output logic [1:0]                  m_axis_tuser
);

    localparam int NSTG = 6;
    localparam int VW   = COORD_BITS + 1;
    localparam int NW   = 2 * COORD_BITS + 3;
    localparam int H    = (NW + 1) / 2;
    localparam int NHW  = NW - H;
    localparam int LW   = H + 1 + VW;
    localparam int HW   = NHW + VW;
    localparam int DW   = NW + VW + 2;

    // configuration registers
    logic                         r_ortho;
    logic signed [COORD_BITS-1:0] r_view [3];
    logic signed [COORD_BITS-1:0] r_eye  [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ortho <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_view[k] <= '0;
                r_eye[k]  <= '0;
            end
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_ORTHO_MODE: r_ortho   <= i_cfg_data[0];
                CFG_VIEW_X:     r_view[0] <= i_cfg_data;
                CFG_VIEW_Y:     r_view[1] <= i_cfg_data;
                CFG_VIEW_Z:     r_view[2] <= i_cfg_data;
                CFG_EYE_X:      r_eye[0]  <= i_cfg_data;
                CFG_EYE_Y:      r_eye[1]  <= i_cfg_data;
                CFG_EYE_Z:      r_eye[2]  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage valid bits and per-stage load enables
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;

    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign s_axis_tready = en[0];

    // unpack the input word
    logic signed [COORD_BITS-1:0] in_a [3];
    logic signed [COORD_BITS-1:0] in_b [3];
    logic signed [COORD_BITS-1:0] in_c [3];
    logic [INDEX_BITS-1:0]        in_idx2;
    logic [INDEX_BITS-1:0]        in_idx3;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            in_a[k] = s_axis_tdata[k*COORD_BITS +: COORD_BITS];
            in_b[k] = s_axis_tdata[(3+k)*COORD_BITS +: COORD_BITS];
            in_c[k] = s_axis_tdata[(6+k)*COORD_BITS +: COORD_BITS];
        end
        in_idx2 = s_axis_tdata[9*COORD_BITS +: INDEX_BITS];
        in_idx3 = s_axis_tdata[9*COORD_BITS+INDEX_BITS +: INDEX_BITS];
    end

    // face normal
    t_cross_ctl              cross_ctl;
    logic signed [NW-1:0]    n_vec [3];

    assign cross_ctl.ld_edge = en[0];
    assign cross_ctl.ld_prod = en[1];
    assign cross_ctl.ld_norm = en[2];

    twor_cross #(
        .COORD_BITS (COORD_BITS)
    ) u_cross (
        .i_clk (i_clk),
        .i_ctl (cross_ctl),
        .i_a   (in_a),
        .i_b   (in_b),
        .i_c   (in_c),
        .o_n   (n_vec)
    );

    // view vector carried alongside the normal stages, indices carried down to the final stage
    logic signed [VW-1:0]  r_v0 [3];
    logic signed [VW-1:0]  r_v1 [3];
    logic signed [VW-1:0]  r_v2 [3];
    logic [INDEX_BITS-1:0] r_idx2 [NSTG-1];
    logic [INDEX_BITS-1:0] r_idx3 [NSTG-1];

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int k = 0; k < 3; k++) begin
                if (r_ortho) begin
                    r_v0[k] <= $signed({r_view[k][COORD_BITS-1], r_view[k]});
                end else begin
                    r_v0[k] <= $signed({r_eye[k][COORD_BITS-1], r_eye[k]})
                             - $signed({in_a[k][COORD_BITS-1], in_a[k]});
                end
            end
        end
        if (en[1]) r_v1 <= r_v0;
        if (en[2]) r_v2 <= r_v1;
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_idx2[0] <= in_idx2;
            r_idx3[0] <= in_idx3;
        end
        for (int k = 1; k < NSTG - 1; k++) begin
            if (en[k]) begin
                r_idx2[k] <= r_idx2[k-1];
                r_idx3[k] <= r_idx3[k-1];
            end
        end
    end

    // dot product: normal split into unsigned low and signed high halves
    logic signed [LW-1:0] r_plo [3];
    logic signed [HW-1:0] r_phi [3];
    logic                 r_degen3;
    logic signed [LW+1:0] r_slo;
    logic signed [HW+1:0] r_shi;
    logic                 r_degen4;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            for (int k = 0; k < 3; k++) begin
                r_plo[k] <= $signed({1'b0, n_vec[k][H-1:0]}) * r_v2[k];
                r_phi[k] <= $signed(n_vec[k][NW-1:H]) * r_v2[k];
            end
            r_degen3 <= (n_vec[0] == '0) && (n_vec[1] == '0) && (n_vec[2] == '0);
        end
        if (en[4]) begin
            r_slo <= $signed({{2{r_plo[0][LW-1]}}, r_plo[0]})
                   + $signed({{2{r_plo[1][LW-1]}}, r_plo[1]})
                   + $signed({{2{r_plo[2][LW-1]}}, r_plo[2]});
            r_shi <= $signed({{2{r_phi[0][HW-1]}}, r_phi[0]})
                   + $signed({{2{r_phi[1][HW-1]}}, r_phi[1]})
                   + $signed({{2{r_phi[2][HW-1]}}, r_phi[2]});
            r_degen4 <= r_degen3;
        end
    end

    // final sum, sign decides the swap
    logic signed [DW-1:0]  dot;
    logic                  swap;
    logic [INDEX_BITS-1:0] r_out2;
    logic [INDEX_BITS-1:0] r_out3;
    logic                  r_swapped;
    logic                  r_degen5;

    assign dot  = $signed({r_shi, {H{1'b0}}})
                + $signed({{(NHW-1){r_slo[LW+1]}}, r_slo});
    assign swap = dot[DW-1] && !r_degen4;

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_out2    <= swap ? r_idx3[4] : r_idx2[4];
            r_out3    <= swap ? r_idx2[4] : r_idx3[4];
            r_swapped <= swap;
            r_degen5  <= r_degen4;
        end
    end

    assign m_axis_tvalid = r_vld[NSTG-1];
    assign m_axis_tdata  = OUT_TDATA_W'({r_out3, r_out2});
    assign m_axis_tuser  = {r_degen5, r_swapped};

endmodule

`default_nettype wire

@@ hdl/twor_cross.sv @@
// three stage face normal unit: edge vectors, partial products, cross product
`timescale 1ns / 1ps
`default_nettype none

module twor_cross
    import twor_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire t_cross_ctl                    i_ctl,
    input  wire logic signed [COORD_BITS-1:0]  i_a [3],
    input  wire logic signed [COORD_BITS-1:0]  i_b [3],
    input  wire logic signed [COORD_BITS-1:0]  i_c [3],
    output logic signed [2*COORD_BITS+2:0]     o_n [3]
);

    localparam int EW = COORD_BITS + 1;
    localparam int PW = 2 * EW;
    localparam int NW = PW + 1;

    logic signed [EW-1:0] r_ab [3];
    logic signed [EW-1:0] r_ac [3];
    logic signed [PW-1:0] r_p  [6];
    logic signed [NW-1:0] r_n  [3];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (i_ctl.ld_edge) begin
                r_ab[k] <= $signed({i_b[k][COORD_BITS-1], i_b[k]})
                         - $signed({i_a[k][COORD_BITS-1], i_a[k]});
                r_ac[k] <= $signed({i_c[k][COORD_BITS-1], i_c[k]})
                         - $signed({i_a[k][COORD_BITS-1], i_a[k]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_prod) begin
            r_p[0] <= r_ab[1] * r_ac[2];
            r_p[1] <= r_ab[2] * r_ac[1];
            r_p[2] <= r_ab[2] * r_ac[0];
            r_p[3] <= r_ab[0] * r_ac[2];
            r_p[4] <= r_ab[0] * r_ac[1];
            r_p[5] <= r_ab[1] * r_ac[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_norm) begin
            for (int k = 0; k < 3; k++) begin
                r_n[k] <= $signed({r_p[2*k][PW-1], r_p[2*k]})
                        - $signed({r_p[2*k+1][PW-1], r_p[2*k+1]});
            end
        end
    end

    assign o_n = r_n;

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// self-checking testbench for the triangle winding orientation core
`timescale 1ns / 1ps

module tb
    import twor_pkg::*;
();

    localparam int CW       = COORD_BITS_DEF;
    localparam int IW       = INDEX_BITS_DEF;
    localparam int PIPE_LAT = 6;

    // register index past the end of the map, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    localparam logic [CW-1:0] C_MAX   = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] C_MIN   = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] ONE     = CW'(256);
    localparam logic [CW-1:0] NEG_ONE = CW'(-256);

    typedef struct packed {
        logic [IW-1:0]      third;
        logic [IW-1:0]      second;
        logic [8:0][CW-1:0] crd;    // a_x, a_y, a_z, b_x .. c_z, a_x lowest
    } t_tri_word;

    typedef struct packed {
        logic          degenerate;
        logic          swapped;
        logic [IW-1:0] third_out;
        logic [IW-1:0] second_out;
    } t_orient;

    typedef logic signed [127:0] t_wide;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = '0;
    logic [CW-1:0]        cfg_data = '0;

    logic          s_tvalid = 1'b0;
    t_tri_word     s_tdata  = '0;
    logic          s_tready;
    logic          m_tvalid;
    logic [2*IW-1:0] m_tdata;
    logic [1:0]    m_tuser;
    logic          m_tready = 1'b0;

    // shadow copy of the register file
    logic          sh_ortho = 1'b0;
    logic [CW-1:0] sh_view [3] = '{default: '0};
    logic [CW-1:0] sh_eye  [3] = '{default: '0};

    t_tri_word tri_q [$];
    t_orient   orient_q [$];
    int        mismatch_cnt = 0;

    triangle_winding_orient_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_idx),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_wide widen(input logic [CW-1:0] x);
        t_wide w;
        w = $signed(x);
        return w;
    endfunction

    // exact normal and facing test, swap the indices when the face points away
    function automatic t_orient orient_triangle(input t_tri_word t);
        t_wide   a [3];
        t_wide   e1 [3];
        t_wide   e2 [3];
        t_wide   nrm [3];
        t_wide   vw [3];
        t_wide   dotp;
        t_orient r;
        int      k;
        for (k = 0; k < 3; k++) begin
            a[k]  = widen(t.crd[k]);
            e1[k] = widen(t.crd[3+k]) - a[k];
            e2[k] = widen(t.crd[6+k]) - a[k];
        end
        nrm[0] = e1[1] * e2[2] - e1[2] * e2[1];
        nrm[1] = e1[2] * e2[0] - e1[0] * e2[2];
        nrm[2] = e1[0] * e2[1] - e1[1] * e2[0];
        r.second_out = t.second;
        r.third_out  = t.third;
        r.swapped    = 1'b0;
        r.degenerate = 1'b0;
        if (nrm[0] == 0 && nrm[1] == 0 && nrm[2] == 0) begin
            r.degenerate = 1'b1;
        end else begin
            for (k = 0; k < 3; k++)
                vw[k] = sh_ortho ? widen(sh_view[k]) : widen(sh_eye[k]) - a[k];
            dotp = nrm[0] * vw[0] + nrm[1] * vw[1] + nrm[2] * vw[2];
            if (dotp < 0) begin
                r.second_out = t.third;
                r.third_out  = t.second;
                r.swapped    = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [CW-1:0] small_coord();
        return CW'($urandom_range(0, 8191)) - CW'(4096);
    endfunction

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return CW'($urandom);
            5, 6:          return small_coord();
            7, 8: begin
                case ($urandom_range(0, 4))
                    0:       return C_MAX;
                    1:       return C_MIN;
                    2:       return '1;
                    3:       return ONE;
                    default: return NEG_ONE;
                endcase
            end
            default:       return '0;
        endcase
    endfunction

    function automatic t_tri_word rand_tri();
        t_tri_word t;
        int        k;
        t.second = IW'($urandom);
        t.third  = IW'($urandom);
        for (k = 0; k < 9; k++)
            t.crd[k] = rand_coord();
        case ($urandom_range(0, 7))
            0: begin
                // c continues the line from a through b
                for (k = 0; k < 3; k++) begin
                    t.crd[k]   = small_coord();
                    t.crd[3+k] = small_coord();
                    t.crd[6+k] = CW'(2) * t.crd[3+k] - t.crd[k];
                end
            end
            1: begin
                for (k = 0; k < 3; k++)
                    t.crd[3+k] = t.crd[k];
            end
            2: begin
                for (k = 0; k < 9; k++)
                    t.crd[k] = small_coord();
            end
            default: ;
        endcase
        return t;
    endfunction

    function automatic t_tri_word mk_tri(input logic [CW-1:0] ax, ay, az, bx, by, bz,
                                         cx, cy, cz, input logic [IW-1:0] i2, i3);
        t_tri_word t;
        t.crd    = {cz, cy, cx, bz, by, bx, az, ay, ax};
        t.second = i2;
        t.third  = i3;
        return t;
    endfunction

    task automatic check_field(input string fname, input logic [IW-1:0] want,
                               input logic [IW-1:0] got);
        if (want !== got) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("%0t: %s expected %h got %h", $time, fname, want, got);
        end
    endtask

    // driver: bursts of words with random gaps
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                orient_q.push_back(orient_triangle(s_tdata));
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (tri_q.size() > 0) begin
                    s_tdata  <= tri_q.pop_front();
                    s_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 15);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result word, ready follows a rolling 16-bit pattern
    logic [15:0] rdy_pat = '1;
    int          rdy_pos = 0;

    always @(posedge i_clk) begin
        t_orient got;
        t_orient want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata};
                if (orient_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: unexpected result word %h", $time, got);
                end else begin
                    want = orient_q.pop_front();
                    check_field("second_index_out", want.second_out, got.second_out);
                    check_field("third_index_out", want.third_out, got.third_out);
                    check_field("swapped", IW'(want.swapped), IW'(got.swapped));
                    check_field("degenerate", IW'(want.degenerate), IW'(got.degenerate));
                end
            end
            m_tready <= rdy_pat[rdy_pos];
            if (rdy_pos == 15) begin
                rdy_pos = 0;
                case ($urandom_range(0, 3))
                    0:       rdy_pat = '1;
                    1:       rdy_pat = 16'($urandom);
                    2:       rdy_pat = 16'($urandom & $urandom);
                    default: rdy_pat = 16'($urandom | $urandom);
                endcase
            end else begin
                rdy_pos++;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            CFG_ORTHO_MODE: sh_ortho   = val[0];
            CFG_VIEW_X:     sh_view[0] = val;
            CFG_VIEW_Y:     sh_view[1] = val;
            CFG_VIEW_Z:     sh_view[2] = val;
            CFG_EYE_X:      sh_eye[0]  = val;
            CFG_EYE_Y:      sh_eye[1]  = val;
            CFG_EYE_Z:      sh_eye[2]  = val;
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [CW-1:0] ortho, vx, vy, vz, ex, ey, ez);
        write_reg(CFG_ORTHO_MODE, ortho);
        write_reg(CFG_VIEW_X, vx);
        write_reg(CFG_VIEW_Y, vy);
        write_reg(CFG_VIEW_Z, vz);
        write_reg(CFG_EYE_X, ex);
        write_reg(CFG_EYE_Y, ey);
        write_reg(CFG_EYE_Z, ez);
    endtask

    task automatic queue_directed();
        // degenerate: all points equal, collinear, first two coincide
        tri_q.push_back(mk_tri('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '1));
        tri_q.push_back(mk_tri(ONE, ONE, ONE, CW'(512), CW'(512), CW'(512),
                               CW'(768), CW'(768), CW'(768), '1, '0));
        tri_q.push_back(mk_tri(C_MAX, C_MIN, ONE, C_MAX, C_MIN, ONE, '0, '0, '0,
                               16'h5555, 16'haaaa));
        // unit triangle below the origin, both windings
        tri_q.push_back(mk_tri('0, '0, NEG_ONE, ONE, '0, NEG_ONE, '0, ONE, NEG_ONE,
                               16'd1, 16'd2));
        tri_q.push_back(mk_tri('0, '0, NEG_ONE, '0, ONE, NEG_ONE, ONE, '0, NEG_ONE,
                               16'd1, 16'd2));
        // eye in the triangle's plane gives a zero dot product
        tri_q.push_back(mk_tri(ONE, ONE, '0, CW'(512), ONE, '0, ONE, CW'(512), '0,
                               16'haaaa, 16'h5555));
        // coordinate extremes, both windings
        tri_q.push_back(mk_tri(C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MIN,
                               '1, '1));
        tri_q.push_back(mk_tri(C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MIN,
                               '1, '0));
        tri_q.push_back(mk_tri(C_MAX, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, C_MAX,
                               16'h00ff, 16'hff00));
        tri_q.push_back(mk_tri('0, '0, '0, C_MAX, '0, '0, '0, '0, C_MAX, 16'h8000, 16'h0001));
        tri_q.push_back(mk_tri('1, '1, '1, '0, '1, '1, '1, '0, '1, 16'h7fff, 16'h8000));
        tri_q.push_back(mk_tri(C_MAX, C_MIN, '0, C_MIN, C_MAX, C_MAX, '0, '0, C_MIN,
                               16'h1234, 16'hfedc));
    endtask

    task automatic run_phase(input bit with_directed, input int n_items);
        @(negedge i_clk);
        if (with_directed)
            queue_directed();
        repeat (n_items) tri_q.push_back(rand_tri());
        // sender stops here until every expected word is back
        do @(negedge i_clk); while (tri_q.size() != 0 || s_tvalid || orient_q.size() != 0);
        repeat (PIPE_LAT + 2) @(negedge i_clk);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: perspective with the eye at the origin
        run_phase(1'b1, 20);
        set_config(CW'(1), '0, '0, ONE, '0, '0, '0);
        run_phase(1'b0, 55);
        // zero view direction never swaps
        set_config(CW'(1), '0, '0, '0, '0, '0, '0);
        run_phase(1'b1, 40);
        set_config(CW'(1), C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MIN);
        write_reg(CFG_SPARE, CW'($urandom));
        run_phase(1'b0, 55);
        set_config(CW'(0), C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MIN);
        run_phase(1'b0, 55);
        set_config(CW'(0), C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MAX);
        run_phase(1'b0, 55);
        set_config(CW'(0), '1, '1, '1, small_coord(), small_coord(), small_coord());
        run_phase(1'b0, 55);
        repeat (4) begin
            set_config(CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom),
                       CW'($urandom), CW'($urandom), CW'($urandom));
            run_phase(1'b0, 55);
        end

        if (mismatch_cnt == 0 && orient_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
